/* hw/rtl/ycp_pkg.sv */
// Package: shared types and constants of the YUV 4:2:0 crop and place block.
`timescale 1ns / 1ps

package ycp_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 16;
    localparam int POS_W      = 13;
    localparam int ADDR_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [POS_W-1:0] ROW_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_SIZE    = 3'd0,
        CFG_RECT_ORIGIN = 3'd1,
        CFG_RECT_SIZE   = 3'd2,
        CFG_DST_SIZE    = 3'd3,
        CFG_DST_ORIGIN  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0]  src_w;
        logic [DIM_W-1:0]  src_h;
        logic [DIM_W-1:0]  rect_x;
        logic [DIM_W-1:0]  rect_y;
        logic [DIM_W-1:0]  rect_w;
        logic [DIM_W-1:0]  rect_h;
        logic [DIM_W-1:0]  dst_w;
        logic [DIM_W-1:0]  dst_h;
        logic [DIM_W-1:0]  dst_x;
        logic [DIM_W-1:0]  dst_y;
        logic [ADDR_W-1:0] u_base;
        logic [ADDR_W-1:0] v_base;
    } cfg_t;

    typedef struct packed {
        logic       start_of_frame;
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } in_item_t;

    typedef struct packed {
        logic              luma_write;
        logic [ADDR_W-1:0] luma_addr;
        logic [7:0]        luma_value;
        logic              chroma_write;
        logic [ADDR_W-1:0] u_addr;
        logic [ADDR_W-1:0] v_addr;
        logic [7:0]        cb_value;
        logic [7:0]        cr_value;
        logic              config_error;
    } out_item_t;

endpackage

/* hw/rtl/ycp_cfg_regs.sv */
// Configuration register file with registered chroma plane bases.
`timescale 1ns / 1ps

module ycp_cfg_regs
    import ycp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CFG_DATA_W-1:0] src_size_reg,    src_size_next;
    logic [CFG_DATA_W-1:0] rect_origin_reg, rect_origin_next;
    logic [CFG_DATA_W-1:0] rect_size_reg,   rect_size_next;
    logic [CFG_DATA_W-1:0] dst_size_reg,    dst_size_next;
    logic [CFG_DATA_W-1:0] dst_origin_reg,  dst_origin_next;
    logic [31:0]           plane_reg,       plane_next;
    logic [ADDR_W-1:0]     v_base_reg,      v_base_next;

    always_comb
    begin
        src_size_next    = src_size_reg;
        rect_origin_next = rect_origin_reg;
        rect_size_next   = rect_size_reg;
        dst_size_next    = dst_size_reg;
        dst_origin_next  = dst_origin_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SRC_SIZE:    src_size_next    = cfg_data;
                CFG_RECT_ORIGIN: rect_origin_next = cfg_data;
                CFG_RECT_SIZE:   rect_size_next   = cfg_data;
                CFG_DST_SIZE:    dst_size_next    = cfg_data;
                CFG_DST_ORIGIN:  dst_origin_next  = cfg_data;
                default:         ;
            endcase
        end
        // luma plane size and V base from the incoming value
        plane_next  = 32'(dst_size_next[15:0]) * 32'(dst_size_next[31:16]);
        v_base_next = plane_next[ADDR_W-1:0] + plane_next[ADDR_W+1:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_size_reg    <= '0;
            rect_origin_reg <= '0;
            rect_size_reg   <= '0;
            dst_size_reg    <= '0;
            dst_origin_reg  <= '0;
            plane_reg       <= '0;
            v_base_reg      <= '0;
        end
        else
        begin
            src_size_reg    <= src_size_next;
            rect_origin_reg <= rect_origin_next;
            rect_size_reg   <= rect_size_next;
            dst_size_reg    <= dst_size_next;
            dst_origin_reg  <= dst_origin_next;
            plane_reg       <= plane_next;
            v_base_reg      <= v_base_next;
        end
    end

    assign cfg.src_w  = src_size_reg[15:0];
    assign cfg.src_h  = src_size_reg[31:16];
    assign cfg.rect_x = rect_origin_reg[15:0];
    assign cfg.rect_y = rect_origin_reg[31:16];
    assign cfg.rect_w = rect_size_reg[15:0];
    assign cfg.rect_h = rect_size_reg[31:16];
    assign cfg.dst_w  = dst_size_reg[15:0];
    assign cfg.dst_h  = dst_size_reg[31:16];
    assign cfg.dst_x  = dst_origin_reg[15:0];
    assign cfg.dst_y  = dst_origin_reg[31:16];
    assign cfg.u_base = plane_reg[ADDR_W-1:0];
    assign cfg.v_base = v_base_reg;

endmodule

/* hw/rtl/ycp_pixel_path.sv */
// Raster position tracking, frame checks, clipping and address generation.
`timescale 1ns / 1ps

module ycp_pixel_path
    import ycp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [POS_W-1:0] column_reg, column_next;
    logic [POS_W-1:0] row_reg,    row_next;
    logic [POS_W-1:0] clip_w_reg, clip_w_next;
    logic [POS_W-1:0] clip_h_reg, clip_h_next;
    logic             frame_bad_reg, frame_bad_next;

    logic             bad;
    logic [DIM_W:0]   w_src_end, w_dst_end, h_src_end, h_dst_end;
    logic [DIM_W-1:0] w_src_cut, w_dst_cut, h_src_cut, h_dst_cut;
    logic [DIM_W:0]   x_end, y_end;
    logic             in_rect;
    logic             odd_site;
    logic [DIM_W:0]   dx, dy;
    logic [32:0]      luma_prod;
    logic [30:0]      chroma_prod;
    logic [ADDR_W-1:0] chroma_off;
    logic [POS_W:0]   col_inc;
    logic             wrap;

    always_comb
    begin
        bad = (cfg.src_w[0] | cfg.src_h[0] | cfg.rect_x[0] | cfg.rect_y[0] |
               cfg.rect_w[0] | cfg.rect_h[0] | cfg.dst_w[0] | cfg.dst_h[0] |
               cfg.dst_x[0] | cfg.dst_y[0]) != 1'b0;
        bad = bad || cfg.src_w > DIM_W'(MAX_DIM) || cfg.src_h > DIM_W'(MAX_DIM) ||
              cfg.dst_w > DIM_W'(MAX_DIM) || cfg.dst_h > DIM_W'(MAX_DIM);
        bad = bad || cfg.rect_x > cfg.src_w || cfg.rect_w > cfg.src_w ||
              cfg.rect_y > cfg.src_h || cfg.rect_h > cfg.src_h;
        bad = bad || cfg.rect_w > cfg.dst_w || cfg.dst_x > cfg.dst_w ||
              cfg.rect_h > cfg.dst_h || cfg.dst_y > cfg.dst_h;

        // cut to source edge, then to destination edge
        w_src_end = {1'b0, cfg.rect_x} + {1'b0, cfg.rect_w};
        w_src_cut = (w_src_end > {1'b0, cfg.src_w}) ? cfg.src_w - cfg.rect_x : cfg.rect_w;
        w_dst_end = {1'b0, w_src_cut} + {1'b0, cfg.dst_x};
        w_dst_cut = (w_dst_end > {1'b0, cfg.dst_w}) ? cfg.dst_w - cfg.dst_x : w_src_cut;
        h_src_end = {1'b0, cfg.rect_y} + {1'b0, cfg.rect_h};
        h_src_cut = (h_src_end > {1'b0, cfg.src_h}) ? cfg.src_h - cfg.rect_y : cfg.rect_h;
        h_dst_end = {1'b0, h_src_cut} + {1'b0, cfg.dst_y};
        h_dst_cut = (h_dst_end > {1'b0, cfg.dst_h}) ? cfg.dst_h - cfg.dst_y : h_src_cut;

        column_next    = column_reg;
        row_next       = row_reg;
        clip_w_next    = clip_w_reg;
        clip_h_next    = clip_h_reg;
        frame_bad_next = frame_bad_reg;
        if (item.start_of_frame)
        begin
            column_next    = '0;
            row_next       = '0;
            frame_bad_next = bad;
            clip_w_next    = bad ? '0 : w_dst_cut[POS_W-1:0];
            clip_h_next    = bad ? '0 : h_dst_cut[POS_W-1:0];
        end

        x_end   = {1'b0, cfg.rect_x} + (DIM_W+1)'(clip_w_next);
        y_end   = {1'b0, cfg.rect_y} + (DIM_W+1)'(clip_h_next);
        in_rect = !frame_bad_next &&
                  DIM_W'(column_next) >= cfg.rect_x && (DIM_W+1)'(column_next) < x_end &&
                  DIM_W'(row_next) >= cfg.rect_y && (DIM_W+1)'(row_next) < y_end;
        odd_site = column_next[0] & row_next[0];

        dx = (DIM_W+1)'(column_next) - {1'b0, cfg.rect_x} + {1'b0, cfg.dst_x};
        dy = (DIM_W+1)'(row_next) - {1'b0, cfg.rect_y} + {1'b0, cfg.dst_y};
        luma_prod   = 33'(dy) * 33'(cfg.dst_w);
        chroma_prod = 31'(dy[DIM_W:1]) * 31'(cfg.dst_w[DIM_W-1:1]);
        chroma_off  = chroma_prod[ADDR_W-1:0] + ADDR_W'(dx[DIM_W:1]);

        result = '0;
        result.config_error = frame_bad_next;
        if (in_rect)
        begin
            result.luma_write = 1'b1;
            result.luma_addr  = luma_prod[ADDR_W-1:0] + ADDR_W'(dx);
            result.luma_value = item.luma;
            if (odd_site)
            begin
                result.chroma_write = 1'b1;
                result.u_addr       = cfg.u_base + chroma_off;
                result.v_addr       = cfg.v_base + chroma_off;
                result.cb_value     = item.cb;
                result.cr_value     = item.cr;
            end
        end

        // advance raster position
        col_inc = {1'b0, column_next} + (POS_W+1)'(1);
        wrap    = DIM_W'(col_inc) >= cfg.src_w || col_inc > {1'b0, ROW_MAX};
        if (wrap)
        begin
            column_next = '0;
            if (row_next < ROW_MAX)
            begin
                row_next = row_next + POS_W'(1);
            end
        end
        else
        begin
            column_next = col_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            clip_w_reg    <= '0;
            clip_h_reg    <= '0;
            frame_bad_reg <= 1'b0;
        end
        else if (step)
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            clip_w_reg    <= clip_w_next;
            clip_h_reg    <= clip_h_next;
            frame_bad_reg <= frame_bad_next;
        end
    end

    a_bad_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        frame_bad_reg |-> (clip_w_reg == '0 && clip_h_reg == '0))
        else $error("clipped size not zero on a bad frame");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(column_reg) && $stable(row_reg) && $stable(frame_bad_reg)))
        else $error("position changed without a transaction");

endmodule

/* hw/rtl/yuv420_crop_and_place.sv */
// Top level: YUV 4:2:0 crop and place, input and result registers around the pixel path.
//
//  Channel  Direction  Handshake                  Payload
//  input    in         in_valid / in_ready        in_data  (in_item_t)
//  result   out        out_valid / out_ready      out_data (out_item_t)
//  config   in         cfg_write                  cfg_index, cfg_data
//
//  One transaction per cycle unless the output stalls; the result is registered.
//  The position update in the pixel path between the two registers sets the rate.
//  Reset clears the configuration, raster position, clipped size and error flag.
//  A stalled result holds; the input register still takes one transaction meanwhile.
`timescale 1ns / 1ps

module yuv420_crop_and_place
    import ycp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t out_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t result;
    logic      advance;
    logic      step;

    ycp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ycp_pixel_path u_pixel_path (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_chroma_needs_luma: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.chroma_write) |-> out_data.luma_write)
        else $error("chroma write without luma write");

    a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.config_error) |-> !out_data.luma_write)
        else $error("write issued on a bad frame");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.luma_write) |->
            (out_data.luma_addr == '0 && out_data.luma_value == '0 &&
             out_data.chroma_write == 1'b0))
        else $error("fields not cleared without a write");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result register not filled after a transaction");

endmodule
